@@ design/ihss_pkg.sv @@
// Shared types, constants and helper functions for the image header size sniffer.
// No dependencies; imported by ihss_parse, image_header_size_sniffer and the testbench.
`default_nettype none

package ihss_pkg;

    // One incoming request: a file byte and the end-of-buffer marker
    typedef struct packed {
        logic [7:0] data_byte;
        logic       final_byte;
    } t_in_item;

    // One result request
    typedef struct packed {
        logic        size_known;
        logic [31:0] image_width;
        logic [31:0] image_height;
    } t_out_item;

    // Byte counter saturates here; also the BMP minimum length
    localparam logic [4:0] POS_SAT     = 5'd26;

    // Minimum buffer lengths per format
    localparam logic [4:0] PNG_MIN     = 5'd24;
    localparam logic [4:0] GIF_MIN     = 5'd10;
    localparam logic [4:0] BMP_MIN     = 5'd26;

    // Signature lengths
    localparam logic [4:0] PNG_SIG_LEN = 5'd8;
    localparam logic [4:0] GIF_SIG_LEN = 5'd6;

    // Dimension field offsets
    localparam logic [4:0] PNG_W_OFS   = 5'd16;
    localparam logic [4:0] PNG_H_OFS   = 5'd20;
    localparam logic [4:0] GIF_W_OFS   = 5'd6;
    localparam logic [4:0] GIF_H_OFS   = 5'd8;
    localparam logic [4:0] BMP_W_OFS   = 5'd18;
    localparam logic [4:0] BMP_H_OFS   = 5'd22;

    // GIF version digit position and its alternative ('9' of GIF89a)
    localparam logic [4:0] GIF_VER_POS = 5'd4;
    localparam logic [7:0] GIF_ALT_VER = 8'h39;

    // BMP magic
    localparam logic [7:0] BMP_SIG0    = 8'h42;
    localparam logic [7:0] BMP_SIG1    = 8'h4D;

    // PNG signature byte at a given offset
    function automatic logic [7:0] png_sig_byte(input logic [2:0] idx);
        logic [7:0] v;
        unique case (idx)
            3'd0:    v = 8'h89;
            3'd1:    v = 8'h50;
            3'd2:    v = 8'h4E;
            3'd3:    v = 8'h47;
            3'd4:    v = 8'h0D;
            3'd5:    v = 8'h0A;
            3'd6:    v = 8'h1A;
            default: v = 8'h0A;
        endcase
        return v;
    endfunction

    // GIF87a signature byte at a given offset (offsets past the end unused)
    function automatic logic [7:0] gif_sig_byte(input logic [2:0] idx);
        logic [7:0] v;
        unique case (idx)
            3'd0:    v = 8'h47;
            3'd1:    v = 8'h49;
            3'd2:    v = 8'h46;
            3'd3:    v = 8'h38;
            3'd4:    v = 8'h37;
            3'd5:    v = 8'h61;
            default: v = 8'h00;
        endcase
        return v;
    endfunction

    // Magnitude of a two's complement word; the most negative value gives 2^31
    function automatic logic [31:0] magnitude32(input logic [31:0] v);
        return v[31] ? (32'd0 - v) : v;
    endfunction

endpackage

`default_nettype wire

@@ design/ihss_parse.sv @@
// Header parser: signature tracking, dimension capture and result formation.
// Depends on ihss_pkg. State advances one byte per i_step; clears after the final byte.
`default_nettype none

module ihss_parse (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_step,
    input  wire ihss_pkg::t_in_item i_item,
    output ihss_pkg::t_out_item     o_result
);
    import ihss_pkg::*;

    logic [4:0]  r_pos,   n_pos;
    logic        r_png,   n_png;
    logic        r_gif,   n_gif;
    logic        r_bmp,   n_bmp;
    logic [31:0] r_w,     n_w;
    logic [31:0] r_h,     n_h;

    logic [7:0]  b;
    logic [4:0]  bmp_w_rel;
    logic [4:0]  bmp_h_rel;
    logic [31:0] res_w;
    logic [31:0] res_h;
    logic        known;

    assign b         = i_item.data_byte;
    assign bmp_w_rel = r_pos - BMP_W_OFS;
    assign bmp_h_rel = r_pos - BMP_H_OFS;

    // Per-byte update: signature compare, then capture by the surviving format
    always_comb begin
        n_pos = r_pos;
        n_png = r_png;
        n_gif = r_gif;
        n_bmp = r_bmp;
        n_w   = r_w;
        n_h   = r_h;
        if (r_pos < POS_SAT) begin
            if (r_pos < PNG_SIG_LEN && b != png_sig_byte(r_pos[2:0])) begin
                n_png = 1'b0;
            end
            if (r_pos < GIF_SIG_LEN &&
                !(b == gif_sig_byte(r_pos[2:0]) ||
                  (r_pos == GIF_VER_POS && b == GIF_ALT_VER))) begin
                n_gif = 1'b0;
            end
            if ((r_pos == 5'd0 && b != BMP_SIG0) || (r_pos == 5'd1 && b != BMP_SIG1)) begin
                n_bmp = 1'b0;
            end

            // PNG: big-endian, shift in; GIF/BMP: little-endian byte lanes
            if (n_png) begin
                if (r_pos >= PNG_W_OFS && r_pos < PNG_H_OFS) begin
                    n_w = {r_w[23:0], b};
                end else if (r_pos >= PNG_H_OFS && r_pos < PNG_MIN) begin
                    n_h = {r_h[23:0], b};
                end
            end else if (n_gif) begin
                if (r_pos == GIF_W_OFS) begin
                    n_w[7:0] = r_w[7:0] | b;
                end else if (r_pos == GIF_W_OFS + 5'd1) begin
                    n_w[15:8] = r_w[15:8] | b;
                end else if (r_pos == GIF_H_OFS) begin
                    n_h[7:0] = r_h[7:0] | b;
                end else if (r_pos == GIF_H_OFS + 5'd1) begin
                    n_h[15:8] = r_h[15:8] | b;
                end
            end else if (n_bmp) begin
                if (r_pos >= BMP_W_OFS && r_pos < BMP_H_OFS) begin
                    n_w = r_w | ({24'd0, b} << {bmp_w_rel[1:0], 3'b000});
                end else if (r_pos >= BMP_H_OFS && r_pos < BMP_MIN) begin
                    n_h = r_h | ({24'd0, b} << {bmp_h_rel[1:0], 3'b000});
                end
            end
            n_pos = r_pos + 5'd1;
        end
    end

    // Result from the updated state; only sampled on the final byte
    always_comb begin
        res_w = 32'd0;
        res_h = 32'd0;
        priority if (n_png && n_pos >= PNG_MIN) begin
            res_w = n_w;
            res_h = n_h;
        end else if (n_gif && n_pos >= GIF_MIN) begin
            res_w = {16'd0, n_w[15:0]};
            res_h = {16'd0, n_h[15:0]};
        end else if (n_bmp && n_pos >= BMP_MIN) begin
            res_w = magnitude32(n_w);
            res_h = magnitude32(n_h);
        end else begin
            res_w = 32'd0;
            res_h = 32'd0;
        end
        known                 = (|res_w) && (|res_h);
        o_result.size_known   = known;
        o_result.image_width  = known ? res_w : 32'd0;
        o_result.image_height = known ? res_h : 32'd0;
    end

    // State registers; a final byte returns everything to the start of a buffer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_step && i_item.final_byte)) begin
            r_pos <= 5'd0;
            r_png <= 1'b1;
            r_gif <= 1'b1;
            r_bmp <= 1'b1;
            r_w   <= 32'd0;
            r_h   <= 32'd0;
        end else if (i_step) begin
            r_pos <= n_pos;
            r_png <= n_png;
            r_gif <= n_gif;
            r_bmp <= n_bmp;
            r_w   <= n_w;
            r_h   <= n_h;
        end
    end

`ifndef SYNTHESIS
    // counter never passes saturation
    a_pos_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos <= POS_SAT)
        else $error("byte counter past saturation");

    // signatures differ in the first byte, so at most one format survives
    a_one_fmt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos != 5'd0 |-> $countones({r_png, r_gif, r_bmp}) <= 1)
        else $error("more than one format still matching");

    // a final byte restarts the buffer
    a_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step && i_item.final_byte |=> r_pos == 5'd0 && r_w == 32'd0 && r_h == 32'd0)
        else $error("state not cleared after final byte");

    // an unknown size reports zero dimensions
    a_zero_unknown: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_result.size_known |-> o_result.image_width == 32'd0 &&
                                 o_result.image_height == 32'd0)
        else $error("nonzero dimensions with unknown size");
`endif

endmodule

`default_nettype wire

@@ design/image_header_size_sniffer.sv @@
// Path: the final byte waits in the input register, then its result is loaded into the result register on o_out_valid.
// Throughput: one byte per cycle; the input register only holds when a final byte
// meets a full, stalled result register.
// Reset: synchronous, active low; empties both registers and restarts at offset zero.
// Top level of the image header size sniffer; depends on ihss_pkg and ihss_parse.
`default_nettype none

module image_header_size_sniffer (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    output logic                     o_in_stall,
    input  wire ihss_pkg::t_in_item  i_in_item,
    output logic                     o_out_valid,
    input  wire logic                i_out_stall,
    output ihss_pkg::t_out_item      o_out_item
);
    import ihss_pkg::*;

    logic      r_s1_valid;
    t_in_item  r_s1_item;
    logic      r_out_valid;
    t_out_item r_out_item;

    logic      s1_block;
    logic      s1_go;
    t_out_item result;

    // Input register moves on unless its final byte has nowhere to put the result
    assign s1_block   = r_s1_item.final_byte && r_out_valid && i_out_stall;
    assign s1_go      = r_s1_valid && !s1_block;
    assign o_in_stall = r_s1_valid && s1_block;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_s1_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall && i_in_valid) begin
            r_s1_item <= i_in_item;
        end
    end

    ihss_parse u_parse (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (s1_go),
        .i_item   (r_s1_item),
        .o_result (result)
    );

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_go && r_s1_item.final_byte) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_go && r_s1_item.final_byte) begin
            r_out_item <= result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

`ifndef SYNTHESIS
    // input side only holds when a result is waiting
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> r_out_valid && i_out_stall && r_s1_item.final_byte)
        else $error("input held without a waiting result");

    // a new result follows only from a processed final byte
    a_result_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(s1_go && r_s1_item.final_byte))
        else $error("result without a final byte");

    // a waiting result is never overwritten
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && i_out_stall |=> r_out_valid && $stable(r_out_item))
        else $error("pending result lost");
`endif

endmodule

`default_nettype wire

@@ tb/ihss_checker.sv @@
`timescale 1ns / 1ps
// Checker for the image header size sniffer: watches both request channels,
// predicts each result from the accepted bytes and compares. Depends on ihss_pkg.

module ihss_checker (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    input  wire logic                i_in_stall,
    input  wire ihss_pkg::t_in_item  i_in_item,
    input  wire logic                i_out_valid,
    input  wire logic                i_out_stall,
    input  wire ihss_pkg::t_out_item i_out_item,
    output int                       o_fail_count,
    output int                       o_pending,
    output int                       o_results_seen,
    output int                       o_sizes_known
);
    import ihss_pkg::*;

    localparam logic [63:0] PNG_MAGIC = 64'h8950_4E47_0D0A_1A0A;
    localparam logic [47:0] GIF_MAGIC = 48'h4749_4638_3761;   // "GIF87a"
    localparam int          MAX_SHOWN = 10;

    // Predictor state, one buffer at a time
    logic [4:0]  sniff_pos;
    logic        png_live;
    logic        gif_live;
    logic        bmp_live;
    logic [31:0] width_acc;
    logic [31:0] height_acc;

    t_out_item   expected_sizes[$];

    initial begin
        o_fail_count   = 0;
        o_pending      = 0;
        o_results_seen = 0;
        o_sizes_known  = 0;
    end

    task automatic clear_sniffer();
        sniff_pos  = '0;
        png_live   = 1'b1;
        gif_live   = 1'b1;
        bmp_live   = 1'b1;
        width_acc  = '0;
        height_acc = '0;
    endtask

    // Advance the predictor by one byte; the final byte queues a size
    task automatic sniff_byte(input logic [7:0] b, input logic last);
        int          ip;
        logic [31:0] w;
        logic [31:0] h;
        t_out_item   size_out;
        ip = int'(sniff_pos);
        if (sniff_pos < POS_SAT) begin
            // signature tracking
            if (sniff_pos < PNG_SIG_LEN) begin
                if (b != PNG_MAGIC[8*(7-ip) +: 8]) png_live = 1'b0;
            end
            if (sniff_pos < GIF_SIG_LEN) begin
                if (b != GIF_MAGIC[8*(5-ip) +: 8] &&
                    !(sniff_pos == GIF_VER_POS && b == GIF_ALT_VER)) gif_live = 1'b0;
            end
            if ((sniff_pos == 5'd0 && b != BMP_SIG0) || (sniff_pos == 5'd1 && b != BMP_SIG1))
                bmp_live = 1'b0;

            // dimension capture for whichever format is still alive
            if (png_live) begin
                if (sniff_pos >= PNG_W_OFS && sniff_pos < PNG_H_OFS)
                    width_acc = {width_acc[23:0], b};
                else if (sniff_pos >= PNG_H_OFS && sniff_pos < PNG_MIN)
                    height_acc = {height_acc[23:0], b};
            end else if (gif_live) begin
                if (sniff_pos >= GIF_W_OFS && sniff_pos < GIF_H_OFS)
                    width_acc |= 32'(b) << (8 * (ip - int'(GIF_W_OFS)));
                else if (sniff_pos >= GIF_H_OFS && sniff_pos < GIF_MIN)
                    height_acc |= 32'(b) << (8 * (ip - int'(GIF_H_OFS)));
            end else if (bmp_live) begin
                if (sniff_pos >= BMP_W_OFS && sniff_pos < BMP_H_OFS)
                    width_acc |= 32'(b) << (8 * (ip - int'(BMP_W_OFS)));
                else if (sniff_pos >= BMP_H_OFS && sniff_pos < BMP_MIN)
                    height_acc |= 32'(b) << (8 * (ip - int'(BMP_H_OFS)));
            end
            sniff_pos = sniff_pos + 5'd1;
        end

        if (last) begin
            w = '0;
            h = '0;
            if (png_live && sniff_pos >= PNG_MIN) begin
                w = width_acc;
                h = height_acc;
            end else if (gif_live && sniff_pos >= GIF_MIN) begin
                w = {16'd0, width_acc[15:0]};
                h = {16'd0, height_acc[15:0]};
            end else if (bmp_live && sniff_pos >= BMP_MIN) begin
                // signed fields, report the magnitude
                w = width_acc[31]  ? 32'd0 - width_acc  : width_acc;
                h = height_acc[31] ? 32'd0 - height_acc : height_acc;
            end
            if (w == '0 || h == '0) begin
                w = '0;
                h = '0;
            end
            size_out.size_known   = (w != '0);
            size_out.image_width  = w;
            size_out.image_height = h;
            expected_sizes.push_back(size_out);
            clear_sniffer();
        end
    endtask

    // Compare one accepted result with the oldest prediction
    task automatic check_size(input t_out_item got);
        t_out_item want;
        o_results_seen++;
        if (got.size_known) o_sizes_known++;
        if (expected_sizes.size() == 0) begin
            if (o_fail_count < MAX_SHOWN)
                $display("%0t: unexpected result known=%0b w=%0d h=%0d", $realtime,
                         got.size_known, got.image_width, got.image_height);
            o_fail_count++;
        end else begin
            want = expected_sizes.pop_front();
            if (got.size_known != want.size_known || got.image_width != want.image_width ||
                got.image_height != want.image_height) begin
                if (o_fail_count < MAX_SHOWN)
                    $display("%0t: size mismatch exp known=%0b w=%0d h=%0d, got %0b %0d %0d",
                             $realtime, want.size_known, want.image_width, want.image_height,
                             got.size_known, got.image_width, got.image_height);
                o_fail_count++;
            end
        end
    endtask

    // Sample both channels on the rising edge
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_sniffer();
            expected_sizes.delete();
        end else begin
            if (i_out_valid && !i_out_stall) check_size(i_out_item);
            if (i_in_valid && !i_in_stall)
                sniff_byte(i_in_item.data_byte, i_in_item.final_byte);
        end
        o_pending = expected_sizes.size();
    end

endmodule

@@ tb/image_header_size_sniffer_test.sv @@
`timescale 1ns / 1ps
// Top of the image header size sniffer testbench: clock, reset, byte stimulus,
// output stalls and verdict. Depends on ihss_pkg, ihss_checker and the block.

module image_header_size_sniffer_test;
    import ihss_pkg::*;

    typedef enum int { FMT_PNG, FMT_GIF87, FMT_GIF89, FMT_BMP, FMT_NOISE } t_fmt;

    localparam logic [63:0] PNG_MAGIC   = 64'h8950_4E47_0D0A_1A0A;
    localparam logic [47:0] GIF_MAGIC   = 48'h4749_4638_3761;
    localparam int          PHASE_BYTES = 310;
    localparam int          HOLD_CYCLES = 300;
    localparam int          MAX_LEN     = 34;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_stall;
    t_in_item    i_in_item;
    logic        o_out_valid;
    logic        i_out_stall;
    t_out_item   o_out_item;

    int          fail_count;
    int          pending;
    int          results_seen;
    int          sizes_known;

    int          send_idle_pct;
    int          recv_idle_pct;
    logic        hold_off_req;
    int          bytes_sent;
    int          files_sent;
    logic [7:0]  file_bytes[$];

    image_header_size_sniffer DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

    ihss_checker u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .i_in_stall     (o_in_stall),
        .i_in_item      (i_in_item),
        .i_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .i_out_item     (o_out_item),
        .o_fail_count   (fail_count),
        .o_pending      (pending),
        .o_results_seen (results_seen),
        .o_sizes_known  (sizes_known)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Hard stop
    initial begin
        #3_000_000;
        $display("FAILURE");
        $finish;
    end

    // Result side: random stalls, plus a long hold-off on request
    initial begin
        int hold_left;
        hold_left = 0;
        forever begin
            @(negedge i_clk);
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                hold_left    = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                i_out_stall <= 1'b1;
                hold_left--;
            end else begin
                i_out_stall <= ($urandom_range(99) < recv_idle_pct);
            end
        end
    end

    // Offer one byte request and wait until it is taken
    task automatic send_byte(input logic [7:0] b, input logic last);
        logic taken;
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_item  <= '{data_byte: b, final_byte: last};
        taken = 1'b0;
        while (!taken) begin
            @(posedge i_clk);
            taken = !o_in_stall;
        end
        bytes_sent++;
        @(negedge i_clk);
    endtask

    task automatic send_file();
        int k;
        for (k = 0; k < file_bytes.size(); k++)
            send_byte(file_bytes[k], k == file_bytes.size() - 1);
        files_sent++;
    endtask

    // Build a file of the given length with a header of the given format
    task automatic make_file(input t_fmt fmt, input logic [31:0] w, input logic [31:0] h,
                             input int len);
        logic [7:0] hdr [0:25];
        int         k;
        for (k = 0; k < 26; k++) hdr[k] = 8'($urandom);
        case (fmt)
            FMT_PNG: begin
                for (k = 0; k < 8; k++) hdr[k] = PNG_MAGIC[8*(7-k) +: 8];
                for (k = 0; k < 4; k++) begin
                    hdr[int'(PNG_W_OFS) + k] = w[8*(3-k) +: 8];
                    hdr[int'(PNG_H_OFS) + k] = h[8*(3-k) +: 8];
                end
            end
            FMT_GIF87, FMT_GIF89: begin
                for (k = 0; k < 6; k++) hdr[k] = GIF_MAGIC[8*(5-k) +: 8];
                if (fmt == FMT_GIF89) hdr[GIF_VER_POS] = GIF_ALT_VER;
                for (k = 0; k < 2; k++) begin
                    hdr[int'(GIF_W_OFS) + k] = w[8*k +: 8];
                    hdr[int'(GIF_H_OFS) + k] = h[8*k +: 8];
                end
            end
            FMT_BMP: begin
                hdr[0] = BMP_SIG0;
                hdr[1] = BMP_SIG1;
                for (k = 0; k < 4; k++) begin
                    hdr[int'(BMP_W_OFS) + k] = w[8*k +: 8];
                    hdr[int'(BMP_H_OFS) + k] = h[8*k +: 8];
                end
            end
            default: ;
        endcase
        file_bytes.delete();
        for (k = 0; k < len; k++) file_bytes.push_back(k < 26 ? hdr[k] : 8'($urandom));
    endtask

    function automatic logic [31:0] pick_dim();
        case ($urandom_range(9))
            0:       return 32'd0;
            1:       return 32'hFFFF_FFFF;
            2:       return 32'h8000_0000;
            3:       return 32'd1;
            4, 5:    return 32'($urandom_range(1, 4096));
            default: return $urandom;
        endcase
    endfunction

    // Mostly well-formed headers with random content, some broken, some noise
    task automatic random_file();
        int   sel;
        int   len;
        int   min_len;
        int   sig_len;
        int   idx;
        t_fmt fmt;
        sel = $urandom_range(99);
        fmt = t_fmt'($urandom_range(3));
        case (fmt)
            FMT_PNG: begin min_len = int'(PNG_MIN); sig_len = int'(PNG_SIG_LEN); end
            FMT_BMP: begin min_len = int'(BMP_MIN); sig_len = 2; end
            default: begin min_len = int'(GIF_MIN); sig_len = int'(GIF_SIG_LEN); end
        endcase
        if (sel < 10) len = $urandom_range(1, MAX_LEN);
        else          len = min_len + int'($urandom_range(0, 8)) - 2;
        if (sel >= 85) begin
            make_file(FMT_NOISE, '0, '0, $urandom_range(1, MAX_LEN));
        end else begin
            make_file(fmt, pick_dim(), pick_dim(), len);
            // spoil one signature byte
            if (sel >= 75) begin
                idx = $urandom_range(0, sig_len - 1);
                if (idx < file_bytes.size()) file_bytes[idx] ^= 8'($urandom_range(1, 255));
            end
        end
        send_file();
    endtask

    task automatic random_phase(input int snd_pct, input int rcv_pct);
        int phase_start;
        send_idle_pct = snd_pct;
        recv_idle_pct = rcv_pct;
        phase_start   = bytes_sent;
        while (bytes_sent - phase_start < PHASE_BYTES) random_file();
    endtask

    // Stimulus and verdict
    initial begin
        int k;
        int guard;
        i_rst_n       = 1'b0;
        i_in_valid    = 1'b0;
        i_in_item     = '0;
        i_out_stall   = 1'b0;
        hold_off_req  = 1'b0;
        send_idle_pct = 35;
        recv_idle_pct = 73;
        bytes_sent    = 0;
        files_sent    = 0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed: extremes, truncation, zero sizes, unknown formats
        make_file(FMT_NOISE, '0, '0, 1);                              send_file();
        make_file(FMT_PNG, 32'd1, 32'd1, int'(PNG_MIN));              send_file();
        make_file(FMT_PNG, 32'hFFFF_FFFF, 32'hFFFF_FFFF, MAX_LEN);    send_file();
        make_file(FMT_PNG, 32'd640, 32'd480, int'(PNG_MIN) - 1);      send_file();
        make_file(FMT_PNG, 32'd0, 32'd5, int'(PNG_MIN));              send_file();
        make_file(FMT_GIF87, 32'hFFFF, 32'd1, int'(GIF_MIN));         send_file();
        make_file(FMT_GIF89, 32'd1, 32'hFFFF, int'(GIF_MIN) + 2);     send_file();
        make_file(FMT_GIF89, 32'd3, 32'd4, int'(GIF_MIN) - 1);        send_file();
        make_file(FMT_GIF87, 32'd9, 32'd0, int'(GIF_MIN));            send_file();
        make_file(FMT_BMP, 32'h8000_0000, 32'hFFFF_FFFF, int'(BMP_MIN)); send_file();
        make_file(FMT_BMP, 32'h7FFF_FFFF, 32'd1, int'(BMP_MIN));      send_file();
        make_file(FMT_BMP, 32'd100, 32'd100, int'(BMP_MIN) - 1);      send_file();
        make_file(FMT_BMP, 32'hFFFF_FFFB, 32'd0, MAX_LEN);            send_file();
        make_file(FMT_BMP, 32'd1, 32'd1, 2);                          send_file();
        // all-zero and all-ones noise
        file_bytes.delete();
        for (k = 0; k < 26; k++) file_bytes.push_back(8'h00);
        send_file();
        file_bytes.delete();
        for (k = 0; k < 26; k++) file_bytes.push_back(8'hFF);
        send_file();

        // Random phases with swapped stall mixes
        random_phase(35, 73);
        random_phase(73, 35);

        // Long output hold-off while short files keep coming
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_off_req  = 1'b1;
        for (k = 0; k < 16; k++) begin
            if (k % 4 == 3) make_file(FMT_GIF89, pick_dim(), pick_dim(), int'(GIF_MIN));
            else            make_file(FMT_NOISE, '0, '0, 1);
            send_file();
        end
        random_phase(0, 0);
        i_in_valid <= 1'b0;

        // Drain, then let the pipeline settle
        guard = 0;
        while (pending != 0 && guard < 20_000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (10) @(posedge i_clk);

        $display("Sent %0d bytes in %0d files (PNG, GIF87a/89a, BMP, broken, noise).",
                 bytes_sent, files_sent);
        $display("Checked %0d results, %0d with a known size, under three stall mixes.",
                 results_seen, sizes_known);
        if (fail_count == 0 && pending == 0) begin
            $display("SUCCESS");
        end else begin
            $display("%0d mismatches, %0d results never arrived", fail_count, pending);
            $display("FAILURE");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
design/ihss_pkg.sv
design/ihss_parse.sv
design/image_header_size_sniffer.sv
tb/ihss_checker.sv
tb/image_header_size_sniffer_test.sv
